### rtl/mft_pkg.sv
// shared types, constants and coding functions of the manchester frame transmitter
package mft_pkg;

    localparam int MAX_PAYLOAD_DEFAULT = 32;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [7:0]  PREAMBLE_BYTE  = 8'h55;
    localparam logic [7:0]  FLAG_BYTE      = 8'h7E;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [15:0] CRC_MSB        = 16'h8000;
    localparam logic [14:0] HALF_BIT_RESET = 15'd125;

    localparam logic OP_HEADER  = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    typedef struct packed {
        logic       is_hdr;
        logic       close;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
    } t_cmd;

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [15:0] manchester(input logic [7:0] b);
        logic [15:0] p;
        p = 16'h0000;
        for (int i = 0; i < 8; i++) begin
            p[2*i+1] = b[i];
            p[2*i]   = ~b[i];
        end
        return p;
    endfunction

endpackage

### rtl/mft_front.sv
// front end: accepts items, clamps length, tracks open frame and issues commands
module mft_front #(
    parameter int MAX_PAYLOAD_BYTES = mft_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_op,
    input  logic [7:0]       i_frame_type,
    input  logic [7:0]       i_seq_num,
    input  logic [7:0]       i_volume,
    input  logic [7:0]       i_payload_len,
    input  logic [7:0]       i_data_byte,
    input  logic             i_q_full,
    output logic             o_push,
    output mft_pkg::t_cmd    o_cmd
);
    import mft_pkg::*;

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD_BYTES);

    logic [7:0] r_bytes_left;
    logic [7:0] n_bytes_left;
    logic [7:0] len_clamped;
    logic [7:0] left_dec;
    logic       accept;

    assign o_ready     = ~i_q_full;
    assign accept      = i_valid & ~i_q_full;
    assign len_clamped = (i_payload_len > MAX_LEN) ? MAX_LEN : i_payload_len;
    assign left_dec    = r_bytes_left - 8'd1;

    always_comb begin
        n_bytes_left = r_bytes_left;
        o_push       = 1'b0;
        o_cmd        = '0;
        if (accept) begin
            if (i_op == OP_HEADER) begin
                o_push       = 1'b1;
                o_cmd.is_hdr = 1'b1;
                o_cmd.close  = (len_clamped == 8'd0);
                o_cmd.b0     = i_frame_type;
                o_cmd.b1     = i_seq_num;
                o_cmd.b2     = len_clamped;
                o_cmd.b3     = i_volume;
                n_bytes_left = len_clamped;
            end else if (r_bytes_left != 8'd0) begin
                o_push       = 1'b1;
                o_cmd.is_hdr = 1'b0;
                o_cmd.close  = (left_dec == 8'd0);
                o_cmd.b0     = i_data_byte;
                n_bytes_left = left_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= 8'd0;
        end else begin
            r_bytes_left <= n_bytes_left;
        end
    end

endmodule

### rtl/mft_queue.sv
// short command queue between front end and back end
module mft_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mft_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output mft_pkg::t_cmd o_cmd
);
    import mft_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

### rtl/mft_back.sv
// back end: steps through frame bytes, runs the crc and drives the output register
module mft_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  mft_pkg::t_cmd i_cmd,
    output logic          o_pop,
    input  logic [14:0]   i_half_bit_ticks,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_coded_byte,
    output logic [15:0]   o_manchester_pattern,
    output logic [14:0]   o_half_duration,
    output logic          o_frame_end
);
    import mft_pkg::*;

    localparam logic [3:0] ST_FIRST  = 4'd0;
    localparam logic [3:0] ST_SOF    = 4'd1;
    localparam logic [3:0] ST_TYPE   = 4'd2;
    localparam logic [3:0] ST_SEQ    = 4'd3;
    localparam logic [3:0] ST_LEN    = 4'd4;
    localparam logic [3:0] ST_VOL    = 4'd5;
    localparam logic [3:0] ST_CRC_HI = 4'd6;
    localparam logic [3:0] ST_CRC_LO = 4'd7;
    localparam logic [3:0] ST_EOF    = 4'd8;

    logic [3:0]  r_step;
    logic [3:0]  n_step;
    logic [15:0] r_crc;
    logic        r_o_valid;
    logic [7:0]  r_byte;
    logic [15:0] r_pattern;
    logic [14:0] r_half;
    logic        r_end;

    logic       fire;
    logic [7:0] sel_byte;
    logic       crc_upd;
    logic       is_last;
    logic       is_end;

    assign fire  = i_q_valid & (~r_o_valid | i_ready);
    assign o_pop = fire & is_last;

    always_comb begin
        sel_byte = FLAG_BYTE;
        crc_upd  = 1'b0;
        is_last  = 1'b0;
        is_end   = 1'b0;
        n_step   = r_step + 4'd1;
        unique case (r_step)
            ST_FIRST: begin
                if (i_cmd.is_hdr) begin
                    sel_byte = PREAMBLE_BYTE;
                end else begin
                    sel_byte = i_cmd.b0;
                    crc_upd  = 1'b1;
                    is_last  = ~i_cmd.close;
                    n_step   = ST_CRC_HI;
                end
            end
            ST_SOF: sel_byte = FLAG_BYTE;
            ST_TYPE: begin
                sel_byte = i_cmd.b0;
                crc_upd  = 1'b1;
            end
            ST_SEQ: begin
                sel_byte = i_cmd.b1;
                crc_upd  = 1'b1;
            end
            ST_LEN: begin
                sel_byte = i_cmd.b2;
                crc_upd  = 1'b1;
            end
            ST_VOL: begin
                sel_byte = i_cmd.b3;
                crc_upd  = 1'b1;
                is_last  = ~i_cmd.close;
            end
            ST_CRC_HI: sel_byte = r_crc[15:8];
            ST_CRC_LO: sel_byte = r_crc[7:0];
            ST_EOF: begin
                sel_byte = FLAG_BYTE;
                is_last  = 1'b1;
                is_end   = 1'b1;
            end
            default: begin
                sel_byte = FLAG_BYTE;
                is_last  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= ST_FIRST;
            r_crc     <= CRC_INIT;
            r_o_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_step    <= is_last ? ST_FIRST : n_step;
                r_o_valid <= 1'b1;
                if (r_step == ST_FIRST && i_cmd.is_hdr) begin
                    r_crc <= CRC_INIT;
                end else if (crc_upd) begin
                    r_crc <= crc_byte(r_crc, sel_byte);
                end
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_byte    <= sel_byte;
            r_pattern <= manchester(sel_byte);
            r_half    <= i_half_bit_ticks;
            r_end     <= is_end;
        end
    end

    assign o_valid              = r_o_valid;
    assign o_coded_byte         = r_byte;
    assign o_manchester_pattern = r_pattern;
    assign o_half_duration      = r_half;
    assign o_frame_end          = r_end;

endmodule

### rtl/manchester_frame_transmitter_unit.sv
// top level of the manchester frame transmitter with crc-16 framing
// the first line byte of an item passes through the command queue and then the back end output register
// throughput: one line byte per cycle out of the back end output register while i_ready is high;
//   a payload item gives 1 line byte (4 when it closes the frame), a header 6 (9 with no payload)
// inputs stall only while the 2-entry command queue is full
// reset: synchronous active low, clears queue and frame state, sets crc to 16'hFFFF; half-bit ticks back to 125
module manchester_frame_transmitter_unit #(
    parameter int MAX_PAYLOAD_BYTES = mft_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [7:0]  i_frame_type,
    input  logic [7:0]  i_seq_num,
    input  logic [7:0]  i_volume,
    input  logic [7:0]  i_payload_len,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_coded_byte,
    output logic [15:0] o_manchester_pattern,
    output logic [14:0] o_half_duration,
    output logic        o_frame_end,
    input  logic        i_cfg_we,
    input  logic [14:0] i_cfg_wdata
);
    import mft_pkg::*;

    logic [14:0] r_half_bit_ticks;
    logic        q_full;
    logic        q_valid;
    logic        push;
    logic        pop;
    t_cmd        push_cmd;
    t_cmd        head_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_bit_ticks <= HALF_BIT_RESET;
        end else if (i_cfg_we) begin
            r_half_bit_ticks <= i_cfg_wdata;
        end
    end

    mft_front #(
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_frame_type  (i_frame_type),
        .i_seq_num     (i_seq_num),
        .i_volume      (i_volume),
        .i_payload_len (i_payload_len),
        .i_data_byte   (i_data_byte),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    mft_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    mft_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_q_valid            (q_valid),
        .i_cmd                (head_cmd),
        .o_pop                (pop),
        .i_half_bit_ticks     (r_half_bit_ticks),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_coded_byte         (o_coded_byte),
        .o_manchester_pattern (o_manchester_pattern),
        .o_half_duration      (o_half_duration),
        .o_frame_end          (o_frame_end)
    );

endmodule

### tb/tb_manchester_frame_transmitter_unit.sv
// self-checking testbench of the manchester frame transmitter: directed table, random frames
module tb_manchester_frame_transmitter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mft_pkg::*;

    localparam int PAYLOAD_CAP   = 32;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DIR_ROWS      = 14;

    typedef struct packed {
        logic       op;
        logic [7:0] ftype;
        logic [7:0] seq;
        logic [7:0] vol;
        logic [7:0] len;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [7:0]  code;
        logic [15:0] pat;
        logic [14:0] half;
        logic        last;
    } line_byte_t;

    typedef struct packed {
        item_t       it;
        logic        typed;
        logic [7:0]  t_code;
        logic [15:0] t_pat;
    } dir_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_op;
    logic [7:0]  i_frame_type;
    logic [7:0]  i_seq_num;
    logic [7:0]  i_volume;
    logic [7:0]  i_payload_len;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_coded_byte;
    logic [15:0] o_manchester_pattern;
    logic [14:0] o_half_duration;
    logic        o_frame_end;
    logic        i_cfg_we;
    logic [14:0] i_cfg_wdata;

    // frame state mirrored by the predictor
    logic [15:0] crc_acc;
    logic [7:0]  bytes_left;
    logic        frame_open;
    logic [14:0] half_ticks;

    line_byte_t  line_q[$];
    dir_row_t    dir_rows [DIR_ROWS];
    int          errors;
    int          useful;
    int          cycles;
    int          stall_left;
    bit          quiet;

    manchester_frame_transmitter_unit #(
        .MAX_PAYLOAD_BYTES(PAYLOAD_CAP)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_op                (i_op),
        .i_frame_type        (i_frame_type),
        .i_seq_num           (i_seq_num),
        .i_volume            (i_volume),
        .i_payload_len       (i_payload_len),
        .i_data_byte         (i_data_byte),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_coded_byte        (o_coded_byte),
        .o_manchester_pattern(o_manchester_pattern),
        .o_half_duration     (o_half_duration),
        .o_frame_end         (o_frame_end),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [15:0] crc16_step(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = c_in;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic item_t random_item(input logic op);
        item_t it;
        it.op    = op;
        it.ftype = 8'($urandom);
        it.seq   = 8'($urandom);
        it.vol   = 8'($urandom);
        it.len   = 8'($urandom);
        it.data  = 8'($urandom);
        return it;
    endfunction

    task automatic queue_line_byte(input logic [7:0] b, input logic last);
        line_byte_t lb;
        lb.code = b;
        lb.pat  = 16'h0000;
        for (int i = 7; i >= 0; i--) begin
            lb.pat = {lb.pat[13:0], b[i], ~b[i]};
        end
        lb.half = half_ticks;
        lb.last = last;
        line_q.push_back(lb);
    endtask

    task automatic queue_trailer();
        queue_line_byte(crc_acc[15:8], 1'b0);
        queue_line_byte(crc_acc[7:0], 1'b0);
        queue_line_byte(FLAG_BYTE, 1'b1);
        frame_open = 1'b0;
        bytes_left = 8'd0;
        crc_acc    = CRC_INIT;
    endtask

    task automatic predict_frame_bytes(input item_t it, output int n);
        int         n0;
        logic [7:0] clen;
        n0 = line_q.size();
        if (it.op == OP_HEADER) begin
            clen    = (it.len > PAYLOAD_CAP) ? 8'(PAYLOAD_CAP) : it.len;
            crc_acc = crc16_step(CRC_INIT, it.ftype);
            crc_acc = crc16_step(crc_acc, it.seq);
            crc_acc = crc16_step(crc_acc, clen);
            crc_acc = crc16_step(crc_acc, it.vol);
            queue_line_byte(PREAMBLE_BYTE, 1'b0);
            queue_line_byte(FLAG_BYTE, 1'b0);
            queue_line_byte(it.ftype, 1'b0);
            queue_line_byte(it.seq, 1'b0);
            queue_line_byte(clen, 1'b0);
            queue_line_byte(it.vol, 1'b0);
            frame_open = 1'b1;
            bytes_left = clen;
            if (clen == 8'd0) begin
                queue_trailer();
            end
        end else if (frame_open) begin
            crc_acc = crc16_step(crc_acc, it.data);
            queue_line_byte(it.data, 1'b0);
            if (bytes_left > 8'd0) begin
                bytes_left = bytes_left - 8'd1;
            end
            if (bytes_left == 8'd0) begin
                queue_trailer();
            end
        end
        n = line_q.size() - n0;
    endtask

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        errors++;
        $display("mismatch %s: got %0h expected %0h", field, got, want);
    endtask

    task automatic send_item(input item_t it, output int first);
        int gap;
        int nres;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_op          = it.op;
        i_frame_type  = it.ftype;
        i_seq_num     = it.seq;
        i_volume      = it.vol;
        i_payload_len = it.len;
        i_data_byte   = it.data;
        i_valid       = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        first = line_q.size();
        predict_frame_bytes(it, nres);
        if (it.op == OP_HEADER || nres > 0) begin
            useful++;
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (line_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_half_ticks(input logic [14:0] v);
        drain_results();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        half_ticks  = v;
    endtask

    task automatic run_frames(input int count);
        int    goal;
        int    len;
        int    eff;
        int    nsend;
        int    first;
        item_t it;
        goal = useful + count;
        while (useful < goal) begin
            if ($urandom_range(0, 15) == 0) begin
                it = random_item(OP_PAYLOAD);
                send_item(it, first);
            end else begin
                case ($urandom_range(0, 9))
                    0:       len = $urandom_range(0, 255);
                    1, 2:    len = $urandom_range(0, PAYLOAD_CAP);
                    default: len = $urandom_range(0, 6);
                endcase
                it     = random_item(OP_HEADER);
                it.len = 8'(len);
                send_item(it, first);
                eff   = (len > PAYLOAD_CAP) ? PAYLOAD_CAP : len;
                // occasionally cut the frame short so the next header abandons it
                nsend = ($urandom_range(0, 11) == 0) ? $urandom_range(0, eff) : eff;
                repeat (nsend) begin
                    it = random_item(OP_PAYLOAD);
                    send_item(it, first);
                end
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (quiet) begin
            i_ready    = 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_ready = 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 4) == 0) begin
            i_ready    = 1'b0;
            stall_left = $urandom_range(0, 4);
        end else begin
            i_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        line_byte_t e;
        if (i_rst_n && o_valid && i_ready) begin
            if (line_q.size() == 0) begin
                report_mismatch("unexpected line byte", o_coded_byte, 0);
            end else begin
                e = line_q.pop_front();
                if (o_coded_byte !== e.code) begin
                    report_mismatch("coded_byte", o_coded_byte, e.code);
                end
                if (o_manchester_pattern !== e.pat) begin
                    report_mismatch("manchester_pattern", o_manchester_pattern, e.pat);
                end
                if (o_half_duration !== e.half) begin
                    report_mismatch("half_duration", o_half_duration, e.half);
                end
                if (o_frame_end !== e.last) begin
                    report_mismatch("frame_end", o_frame_end, e.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_manchester_frame_transmitter_unit failed");
            $finish;
        end
    end

    initial begin
        int first;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_ready       = 1'b0;
        i_op          = OP_HEADER;
        i_frame_type  = 8'h00;
        i_seq_num     = 8'h00;
        i_volume      = 8'h00;
        i_payload_len = 8'h00;
        i_data_byte   = 8'h00;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 15'd0;
        crc_acc       = CRC_INIT;
        bytes_left    = 8'd0;
        frame_open    = 1'b0;
        half_ticks    = HALF_BIT_RESET;
        errors        = 0;
        useful        = 0;
        cycles        = 0;
        stall_left    = 0;
        quiet         = 1'b0;

        // op, type, seq, volume, length, data, typed, first byte, its pattern
        dir_rows = '{
            '{'{OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'hA5}, 1'b0, 8'h00, 16'h0000},
            '{'{OP_HEADER,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 8'h55, 16'h6666},
            '{'{OP_HEADER,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, 8'h55, 16'h6666},
            '{'{OP_HEADER,  8'h12, 8'h34, 8'h56, 8'h02, 8'h00}, 1'b0, 8'h00, 16'h0000},
            '{'{OP_PAYLOAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00}, 1'b1, 8'h00, 16'h5555},
            '{'{OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF}, 1'b1, 8'hFF, 16'hAAAA},
            '{'{OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3C}, 1'b0, 8'h00, 16'h0000},
            '{'{OP_HEADER,  8'h80, 8'h01, 8'h7F, 8'h01, 8'h00}, 1'b0, 8'h00, 16'h0000},
            '{'{OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80}, 1'b0, 8'h00, 16'h0000},
            '{'{OP_HEADER,  8'h21, 8'h43, 8'h65, 8'h21, 8'h00}, 1'b0, 8'h00, 16'h0000},
            '{'{OP_HEADER,  8'h0F, 8'hF0, 8'hAA, 8'h03, 8'h00}, 1'b0, 8'h00, 16'h0000},
            '{'{OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h55}, 1'b1, 8'h55, 16'h6666},
            '{'{OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAA}, 1'b1, 8'hAA, 16'h9999},
            '{'{OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7E}, 1'b0, 8'h00, 16'h0000}
        };

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r]) begin
            send_item(dir_rows[r].it, first);
            if (dir_rows[r].typed) begin
                line_q[first].code = dir_rows[r].t_code;
                line_q[first].pat  = dir_rows[r].t_pat;
                line_q[first].half = HALF_BIT_RESET;
            end
        end

        set_half_ticks(15'd1);
        run_frames(90);
        drain_results();
        run_frames(40);
        set_half_ticks(15'h7FFF);
        run_frames(90);
        set_half_ticks(15'd0);
        run_frames(60);
        set_half_ticks(15'($urandom_range(1, 32767)));
        run_frames(60);
        set_half_ticks(HALF_BIT_RESET);
        quiet = 1'b1;
        run_frames(70);

        drain_results();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_manchester_frame_transmitter_unit passed");
        end else begin
            $display("tb_manchester_frame_transmitter_unit failed");
        end
        $finish;
    end

endmodule
